/* rtl/s2a_pkg.sv */
`default_nettype none

package s2a_pkg;

   // field widths
   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 8;

   // ascii codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

   // bcd digit row: 2^32 needs ten decimal digits
   localparam int NUM_DIGITS    = 10;
   localparam int DIGIT_W       = 4;
   localparam int IDX_W         = $clog2(NUM_DIGITS);
   localparam int BITS_PER_STEP = 2;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(CONV_STEPS);

   // line size and character count
   localparam int MAX_CHARS  = 16;
   localparam int TEXT_CAP   = 11;
   localparam int CHAR_LIMIT = (MAX_CHARS < 1) ? 1 :
                               ((MAX_CHARS > TEXT_CAP) ? TEXT_CAP : MAX_CHARS);
   localparam int CNT_W      = $clog2(TEXT_CAP + 1);

   typedef logic [DIGIT_W-1:0] digit_type;

   // control handed to every cell of the row
   typedef struct packed {
      logic clear;
      logic step;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

endpackage

`default_nettype wire

/* rtl/s2a_cell.sv */
`default_nettype none

module s2a_cell
   import s2a_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_ctrl_type            ctrl,
   input  wire logic [BITS_PER_STEP-1:0] bits_in,
   output logic      [BITS_PER_STEP-1:0] bits_out,
   output digit_type                     digit
);

   digit_type digit_ff;
   digit_type digit_in;
   digit_type adj1;
   digit_type mid;
   digit_type adj2;

   // add three to a digit of five or more before it doubles
   function automatic digit_type bcd_adjust(input digit_type d);
      bcd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

   // two shift-and-adjust steps, upper input bit first
   always_comb begin
      adj1     = bcd_adjust(digit_ff);
      mid      = {adj1[DIGIT_W-2:0], bits_in[1]};
      adj2     = bcd_adjust(mid);
      bits_out = {adj1[DIGIT_W-1], adj2[DIGIT_W-1]};
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.step) begin
         digit_in = {adj2[DIGIT_W-2:0], bits_in[0]};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire

/* rtl/s2a_chain.sv */
`default_nettype none

module s2a_chain
   import s2a_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_ctrl_type            ctrl,
   input  wire logic [BITS_PER_STEP-1:0] bits_in,
   output digit_type [NUM_DIGITS-1:0]    digits
);

   // carries between neighbouring cells, lowest digit fed from the magnitude
   logic [BITS_PER_STEP-1:0] carry [NUM_DIGITS+1];

   assign carry[0] = bits_in;

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      s2a_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .bits_in  (carry[i]),
         .bits_out (carry[i+1]),
         .digit    (digits[i])
      );
   end

endmodule

`default_nettype wire

/* rtl/signed_int_to_ascii_decimal_top.sv */
`default_nettype none

// output: after the conversion, a sign char for a negative number, then the digits at
//    one char per cycle while the output is not held by back-pressure
// input: a new number is taken only in idle, once the last char of the previous one is
//    loaded; the 16-step bcd cell row takes two magnitude bits per step
// reset: synchronous, clears the sequencer and the output valid

module signed_int_to_ascii_decimal_top
   import s2a_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // char_code[7:0]
   output logic             rsp_tlast
);

   state_type                state_ff,  state_in;
   logic [VALUE_W-1:0]       mag_ff,    mag_in;
   logic                     neg_ff,    neg_in;
   logic [STEP_W-1:0]        step_ff,   step_in;
   logic [IDX_W-1:0]         idx_ff,    idx_in;
   logic [CNT_W-1:0]         cnt_ff,    cnt_in;
   logic                     ovalid_ff, ovalid_in;
   logic [CHAR_W-1:0]        ochar_ff,  ochar_in;
   logic                     olast_ff,  olast_in;

   cell_ctrl_type            ctrl;
   digit_type [NUM_DIGITS-1:0] digits;
   logic [IDX_W-1:0]         top_idx;
   digit_type                cur_digit;
   logic                     req_beat;
   logic                     can_load;
   logic                     at_limit;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign can_load   = !ovalid_ff || rsp_tready;
   assign at_limit   = (cnt_ff == CNT_W'(CHAR_LIMIT - 1));

   // row of bcd cells
   assign ctrl.clear = req_beat;
   assign ctrl.step  = (state_ff == ST_CONV);

   s2a_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .bits_in (mag_ff[VALUE_W-1 -: BITS_PER_STEP]),
      .digits  (digits)
   );

   // highest non-zero digit, zero when all are zero
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digits[i] != '0) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   assign cur_digit = digits[idx_ff];

   // sequencer and output register
   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               neg_in   = req_tdata[VALUE_W-1];
               mag_in   = req_tdata[VALUE_W-1] ? (VALUE_W'(0) - req_tdata) : req_tdata;
               step_in  = '0;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in  = mag_ff << BITS_PER_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            idx_in = top_idx;
            if (!neg_ff) begin
               state_in = ST_DIGIT;
            end else if (can_load) begin
               ovalid_in = 1'b1;
               ochar_in  = ASCII_MINUS;
               olast_in  = at_limit;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = at_limit ? ST_IDLE : ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (can_load) begin
               ovalid_in = 1'b1;
               ochar_in  = ASCII_ZERO + CHAR_W'(cur_digit);
               olast_in  = at_limit || (idx_ff == '0);
               cnt_in    = cnt_ff + 1'b1;
               idx_in    = idx_ff - 1'b1;
               if (at_limit || (idx_ff == '0)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      step_ff  <= step_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = ochar_ff;
   assign rsp_tlast  = olast_ff;

`ifndef ASSERT_OFF
   // an accepted number always starts the conversion
   a_accept_conv: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_CONV))
      else $error("accepted beat did not start conversion");

   // digit readout stays inside the row and reads valid bcd
   a_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) |-> (idx_ff < IDX_W'(NUM_DIGITS)) && (cur_digit <= 4'd9))
      else $error("digit readout out of range or not bcd");

   // a held char stays put until its beat
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("held char changed before its beat");

   // a char still held during conversion must end the previous number
   a_conv_pending_last: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && (state_ff == ST_CONV)) |-> olast_ff)
      else $error("non-final char pending during conversion");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
   import s2a_pkg::*;

   // one character of the expected decimal text
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   localparam int RANDOM_VALUES = 290;
   localparam int STALL_LIMIT   = 4000;
   localparam int CALM_FROM     = 3000;
   localparam int CALM_TO       = 4500;
   localparam int DRAIN_CYCLES  = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [CHAR_W-1:0]   rsp_tdata;
   logic                rsp_tlast;

   logic [VALUE_W-1:0]  values_to_send[$];
   text_char_type       pending_chars[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  quiet_cycles = 0;

   signed_int_to_ascii_decimal_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock and reset
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // random idling, none inside the calm window
   function automatic bit take_a_break();
      if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
         return 1'b0;
      return $urandom_range(0, 99) < 17;
   endfunction

   // decimal text of one value, sign first, cut to the line size
   task automatic predict_text(input logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] mag;
      logic [CHAR_W-1:0]  chars[$];
      text_char_type      ch;
      mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
      if (mag == 0)
         chars.push_front(ASCII_ZERO);
      while (mag != 0) begin
         chars.push_front(CHAR_W'(ASCII_ZERO + mag % 10));
         mag = mag / 10;
      end
      if (raw[VALUE_W-1])
         chars.push_front(ASCII_MINUS);
      while (chars.size() > CHAR_LIMIT)
         void'(chars.pop_back());
      foreach (chars[i]) begin
         ch.code = chars[i];
         ch.last = (i == chars.size() - 1);
         pending_chars.push_back(ch);
      end
   endtask

   // input driver: offer queued values, predict on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_text(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (values_to_send.size() != 0 && !take_a_break()) begin
               req_tvalid <= 1'b1;
               req_tdata  <= values_to_send.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // output monitor: random back-pressure and character check
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_a_break();
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               $display("%0t: unexpected beat char=%0d last=%0b", $time, rsp_tdata,
                        rsp_tlast);
               error_count++;
            end else begin
               text_char_type want;
               want = pending_chars.pop_front();
               if (rsp_tdata !== want.code) begin
                  $display("%0t: char expected %0d actual %0d", $time, want.code,
                           rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last,
                           rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      logic [VALUE_W-1:0] val;
      logic [VALUE_W-1:0] pow;
      int                 sel;
      int                 k;

      // directed: zero, single digits, decade edges, extremes, bit patterns
      values_to_send.push_back(32'd0);
      values_to_send.push_back(32'd1);
      values_to_send.push_back(32'hFFFF_FFFF);
      values_to_send.push_back(32'd9);
      values_to_send.push_back(32'd10);
      values_to_send.push_back(-32'sd9);
      values_to_send.push_back(-32'sd10);
      values_to_send.push_back(32'd99);
      values_to_send.push_back(32'd100);
      values_to_send.push_back(32'd999_999_999);
      values_to_send.push_back(32'd1_000_000_000);
      values_to_send.push_back(-32'sd999_999_999);
      values_to_send.push_back(-32'sd1_000_000_000);
      values_to_send.push_back(32'h7FFF_FFFF);
      values_to_send.push_back(32'h8000_0000);
      values_to_send.push_back(32'h8000_0001);
      values_to_send.push_back(32'h7FFF_FFFE);
      values_to_send.push_back(32'h5555_5555);
      values_to_send.push_back(32'hAAAA_AAAA);
      values_to_send.push_back(32'd1_234_567_890);
      values_to_send.push_back(-32'sd1_234_567_890);

      // random: full range, small numbers, decade edges, extremes
      repeat (RANDOM_VALUES) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) begin
            val = $urandom;
         end else if (sel < 7) begin
            val = $urandom_range(0, 999);
            if ($urandom_range(0, 1))
               val = ~val + 1'b1;
         end else if (sel < 9) begin
            k   = $urandom_range(0, 9);
            pow = 1;
            repeat (k) pow = pow * 10;
            val = pow + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1))
               val = ~val + 1'b1;
         end else begin
            val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            val = val ^ $urandom_range(0, 3);
         end
         values_to_send.push_back(val);
      end

      // drain: sample between edges so the driver's updates have settled
      @(negedge reset);
      do
         @(negedge clock);
      while (values_to_send.size() != 0 || req_tvalid || pending_chars.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/s2a_pkg.sv
rtl/s2a_cell.sv
rtl/s2a_chain.sv
rtl/signed_int_to_ascii_decimal_top.sv
sim/tb.sv
